[rtl/core/hbef_pkg.sv]
package hbef_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;
    localparam int SPAN_BITS  = OUT_BITS + 1;
    localparam int EFF_W      = COORD_BITS + 1;
    localparam int DIM_W      = 11;
    localparam int COEF_W     = 32;
    localparam int PROD_W     = COORD_BITS + 1 + COEF_W;
    localparam int ACC_W      = COORD_BITS + 36;
    localparam int Q_W        = OUT_BITS + 2;
    localparam int NUM_W      = ACC_W + Q_W;
    localparam int CNT_W      = $clog2(Q_W + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MAC_STEPS  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_H_PAIR_0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_H_PAIR_1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_H_PAIR_2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_H_PAIR_3       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_H_LAST         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_HEIGHT  = 3'd6;

    localparam logic [CFG_DATA_W-1:0] RST_H_PAIR_0     = 64'd1048576;
    localparam logic [CFG_DATA_W-1:0] RST_H_PAIR_1     = 64'd0;
    localparam logic [CFG_DATA_W-1:0] RST_H_PAIR_2     = 64'd1048576;
    localparam logic [CFG_DATA_W-1:0] RST_H_PAIR_3     = 64'd0;
    localparam logic [COEF_W-1:0]     RST_H_LAST       = 32'd1048576;
    localparam logic [DIM_W-1:0]      RST_SENSOR_WIDTH  = 11'd304;
    localparam logic [DIM_W-1:0]      RST_SENSOR_HEIGHT = 11'd240;

    localparam logic REQ_BOX   = 1'b0;
    localparam logic REQ_EVENT = 1'b1;
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_BOX   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_XSTART,
        S_XWAIT,
        S_YSTART,
        S_YWAIT,
        S_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_DONE
    } div_state_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] p;
        logic signed [ACC_W-1:0] w;
        logic [DIM_W-1:0]        dim;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [OUT_BITS-1:0] q;
    } div_rsp_t;

    function automatic logic [EFF_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        if (int'(d) > (1 << COORD_BITS))
        begin
            return EFF_W'(1 << COORD_BITS);
        end
        return EFF_W'(d);
    endfunction

    function automatic logic [OUT_BITS-1:0] upper_bound(input logic [EFF_W-1:0] e);
        logic [EFF_W-1:0] m1;
        m1 = e - EFF_W'(1);
        return OUT_BITS'(m1) << FRAC_BITS;
    endfunction

endpackage

[rtl/core/hbef_if.sv]
interface hbef_in_if
    import hbef_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [COORD_BITS-1:0] event_col;
    logic [COORD_BITS-1:0] event_row;
    logic [COORD_BITS-1:0] box_min_row;
    logic [COORD_BITS-1:0] box_min_col;
    logic [COORD_BITS-1:0] box_max_row;
    logic [COORD_BITS-1:0] box_max_col;

    modport source (output valid, req_type, event_col, event_row, box_min_row, box_min_col,
                    box_max_row, box_max_col, input ready);
    modport sink (input valid, req_type, event_col, event_row, box_min_row, box_min_col,
                  box_max_row, box_max_col, output ready);
endinterface

interface hbef_out_if
    import hbef_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [COORD_BITS-1:0]       pass_col;
    logic [COORD_BITS-1:0]       pass_row;
    logic [OUT_BITS-1:0]         box_origin_col;
    logic [OUT_BITS-1:0]         box_origin_row;
    logic signed [SPAN_BITS-1:0] box_span_cols;
    logic signed [SPAN_BITS-1:0] box_span_rows;

    modport source (output valid, result_kind, pass_col, pass_row, box_origin_col,
                    box_origin_row, box_span_cols, box_span_rows, input ready);
    modport sink (input valid, result_kind, pass_col, pass_row, box_origin_col,
                  box_origin_row, box_span_cols, box_span_rows, output ready);
endinterface

interface hbef_cfg_if
    import hbef_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/hbef_div.sv]
module hbef_div
    import hbef_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    div_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [NUM_W-1:0]      den_reg;
    logic [Q_W-1:0]        q_reg;
    logic                  neg_reg, pneg_reg, wzero_reg, dzero_reg;
    logic [OUT_BITS-1:0]   hi_reg;
    logic [ACC_W-1:0]      pm, wm;
    logic [EFF_W-1:0]      eff;
    logic                  fits;

    assign pm   = req.p[ACC_W-1] ? ACC_W'(-req.p) : ACC_W'(req.p);
    assign wm   = req.w[ACC_W-1] ? ACC_W'(-req.w) : ACC_W'(req.w);
    assign eff  = eff_dim(req.dim);
    assign fits = rem_reg >= den_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:  state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && req.start)
        begin
            rem_reg   <= NUM_W'(pm) << FRAC_BITS;
            den_reg   <= NUM_W'(wm) << (Q_W - 1);
            cnt_reg   <= CNT_W'(Q_W);
            q_reg     <= '0;
            pneg_reg  <= req.p[ACC_W-1];
            neg_reg   <= req.p[ACC_W-1] ^ req.w[ACC_W-1];
            wzero_reg <= (req.w == '0);
            dzero_reg <= (eff == '0);
            hi_reg    <= upper_bound(eff);
        end
        else if (state_reg == D_RUN)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - den_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], fits};
            den_reg <= den_reg >> 1;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp.done = (state_reg == D_DONE);
        if (dzero_reg)
        begin
            rsp.q = '0;
        end
        else if (wzero_reg)
        begin
            rsp.q = pneg_reg ? '0 : hi_reg;
        end
        else if (neg_reg || q_reg == '0)
        begin
            rsp.q = '0;
        end
        else if (q_reg > Q_W'(hi_reg))
        begin
            rsp.q = hi_reg;
        end
        else
        begin
            rsp.q = q_reg[OUT_BITS-1:0];
        end
    end

endmodule

[rtl/core/homography_box_event_filter.sv]
// Filters address events against a box that is mapped through a 3x3 homography. An event word
// is checked against the sensor and the stored box at acceptance and, if it passes, lands in
// the output register at once, so events stream at one word per cycle while that register
// drains. For each of the two corners of a box update word, one shared 11 by 32 bit multiplier
// accumulates the six products, and one shared restoring divider produces the column and then
// the row quotient; then the output register is loaded with the box once it is free. The input
// is not ready while a box update is in progress.
module homography_box_event_filter
    import hbef_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    hbef_in_if.sink     in_ch,
    hbef_out_if.source  out_ch,
    hbef_cfg_if.sink    cfg_ch
);

    logic [CFG_DATA_W-1:0] h_pair_0_reg, h_pair_1_reg, h_pair_2_reg, h_pair_3_reg;
    logic [COEF_W-1:0]     h_last_reg;
    logic [DIM_W-1:0]      sensor_width_reg, sensor_height_reg;

    logic [OUT_BITS-1:0]   lim_min_col_reg, lim_max_col_reg, lim_min_row_reg, lim_max_row_reg;

    ctrl_state_t           state_reg, state_next;
    logic [2:0]            mac_cnt_reg;
    logic                  corner_reg;
    logic [COORD_BITS-1:0] c0_reg, r0_reg, c1_reg, r1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  px_reg, py_reg, pw_reg;

    logic                        out_valid_reg;
    logic                        out_kind_reg;
    logic [COORD_BITS-1:0]       out_col_reg, out_row_reg;
    logic [OUT_BITS-1:0]         out_ocol_reg, out_orow_reg;
    logic signed [SPAN_BITS-1:0] out_scol_reg, out_srow_reg;

    logic                     slot_free, in_fire, ev_pass, box_load, mac_done;
    logic [COORD_BITS-1:0]    coord_sel, cur_c, cur_r;
    logic signed [COEF_W-1:0] coef_sel;
    logic [2:0]               acc_step;
    logic [OUT_BITS-1:0]      ev_cq, ev_rq;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_pair_0_reg      <= RST_H_PAIR_0;
            h_pair_1_reg      <= RST_H_PAIR_1;
            h_pair_2_reg      <= RST_H_PAIR_2;
            h_pair_3_reg      <= RST_H_PAIR_3;
            h_last_reg        <= RST_H_LAST;
            sensor_width_reg  <= RST_SENSOR_WIDTH;
            sensor_height_reg <= RST_SENSOR_HEIGHT;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_H_PAIR_0:      h_pair_0_reg      <= cfg_ch.data;
                CFG_H_PAIR_1:      h_pair_1_reg      <= cfg_ch.data;
                CFG_H_PAIR_2:      h_pair_2_reg      <= cfg_ch.data;
                CFG_H_PAIR_3:      h_pair_3_reg      <= cfg_ch.data;
                CFG_H_LAST:        h_last_reg        <= cfg_ch.data[COEF_W-1:0];
                CFG_SENSOR_WIDTH:  sensor_width_reg  <= cfg_ch.data[DIM_W-1:0];
                CFG_SENSOR_HEIGHT: sensor_height_reg <= cfg_ch.data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign mac_done  = (mac_cnt_reg == 3'(MAC_STEPS));
    assign cur_c     = corner_reg ? c1_reg : c0_reg;
    assign cur_r     = corner_reg ? r1_reg : r0_reg;
    assign ev_cq     = OUT_BITS'(in_ch.event_col) << FRAC_BITS;
    assign ev_rq     = OUT_BITS'(in_ch.event_row) << FRAC_BITS;

    assign ev_pass = ({1'b0, in_ch.event_col} < EFF_W'(eff_dim(sensor_width_reg)))
                  && ({1'b0, in_ch.event_row} < EFF_W'(eff_dim(sensor_height_reg)))
                  && (ev_cq >= lim_min_col_reg) && (ev_cq <= lim_max_col_reg)
                  && (ev_rq >= lim_min_row_reg) && (ev_rq <= lim_max_row_reg);

    always_comb
    begin
        coord_sel = mac_cnt_reg[0] ? cur_r : cur_c;
        case (mac_cnt_reg)
            3'd0:    coef_sel = $signed(h_pair_0_reg[31:0]);
            3'd1:    coef_sel = $signed(h_pair_1_reg[63:32]);
            3'd2:    coef_sel = $signed(h_pair_0_reg[63:32]);
            3'd3:    coef_sel = $signed(h_pair_2_reg[31:0]);
            3'd4:    coef_sel = $signed(h_pair_1_reg[31:0]);
            3'd5:    coef_sel = $signed(h_pair_2_reg[63:32]);
            default: coef_sel = '0;
        endcase
    end

    assign acc_step = mac_cnt_reg - 3'd1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_ch.req_type == REQ_BOX)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (mac_done)
                begin
                    state_next = S_XSTART;
                end
            end
            S_XSTART: state_next = S_XWAIT;
            S_XWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_YSTART;
                end
            end
            S_YSTART: state_next = S_YWAIT;
            S_YWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = corner_reg ? S_OUT : S_MAC;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready   = (state_reg == S_IDLE) && slot_free;
        box_load      = (state_reg == S_OUT) && slot_free;
        div_req.start = (state_reg == S_XSTART) || (state_reg == S_YSTART);
        div_req.w     = pw_reg;
        if (state_reg == S_XSTART || state_reg == S_XWAIT)
        begin
            div_req.p   = px_reg;
            div_req.dim = sensor_width_reg;
        end
        else
        begin
            div_req.p   = py_reg;
            div_req.dim = sensor_height_reg;
        end
    end

    hbef_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mac_cnt_reg     <= '0;
            corner_reg      <= 1'b0;
            lim_min_col_reg <= '0;
            lim_max_col_reg <= '0;
            lim_min_row_reg <= '0;
            lim_max_row_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && in_fire && in_ch.req_type == REQ_BOX)
            begin
                mac_cnt_reg <= '0;
                corner_reg  <= 1'b0;
            end
            else if (state_reg == S_MAC && !mac_done)
            begin
                mac_cnt_reg <= mac_cnt_reg + 3'd1;
            end
            else if (state_reg == S_XWAIT && div_rsp.done)
            begin
                if (corner_reg)
                begin
                    lim_max_col_reg <= div_rsp.q;
                end
                else
                begin
                    lim_min_col_reg <= div_rsp.q;
                end
            end
            else if (state_reg == S_YWAIT && div_rsp.done)
            begin
                if (corner_reg)
                begin
                    lim_max_row_reg <= div_rsp.q;
                end
                else
                begin
                    lim_min_row_reg <= div_rsp.q;
                end
                corner_reg  <= 1'b1;
                mac_cnt_reg <= '0;
            end

            if (in_fire && in_ch.req_type == REQ_EVENT && ev_pass)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (box_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.req_type == REQ_BOX)
        begin
            c0_reg <= in_ch.box_min_col;
            r0_reg <= in_ch.box_min_row;
            c1_reg <= in_ch.box_max_col;
            r1_reg <= in_ch.box_max_row;
        end

        if ((in_fire && in_ch.req_type == REQ_BOX) || (state_reg == S_YWAIT && div_rsp.done))
        begin
            px_reg <= ACC_W'($signed(h_pair_3_reg[31:0]));
            py_reg <= ACC_W'($signed(h_pair_3_reg[63:32]));
            pw_reg <= ACC_W'($signed(h_last_reg));
        end
        else if (state_reg == S_MAC && mac_cnt_reg != 3'd0)
        begin
            case (acc_step[2:1])
                2'd0:    px_reg <= px_reg + ACC_W'(prod_reg);
                2'd1:    py_reg <= py_reg + ACC_W'(prod_reg);
                default: pw_reg <= pw_reg + ACC_W'(prod_reg);
            endcase
        end

        if (state_reg == S_MAC && !mac_done)
        begin
            prod_reg <= $signed({1'b0, coord_sel}) * coef_sel;
        end

        if (in_fire && in_ch.req_type == REQ_EVENT && ev_pass)
        begin
            out_kind_reg <= KIND_EVENT;
            out_col_reg  <= in_ch.event_col;
            out_row_reg  <= in_ch.event_row;
            out_ocol_reg <= '0;
            out_orow_reg <= '0;
            out_scol_reg <= '0;
            out_srow_reg <= '0;
        end
        else if (box_load)
        begin
            out_kind_reg <= KIND_BOX;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ocol_reg <= lim_min_col_reg;
            out_orow_reg <= lim_min_row_reg;
            out_scol_reg <= $signed({1'b0, lim_max_col_reg}) - $signed({1'b0, lim_min_col_reg});
            out_srow_reg <= $signed({1'b0, lim_max_row_reg}) - $signed({1'b0, lim_min_row_reg});
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.result_kind    = out_kind_reg;
    assign out_ch.pass_col       = out_col_reg;
    assign out_ch.pass_row       = out_row_reg;
    assign out_ch.box_origin_col = out_ocol_reg;
    assign out_ch.box_origin_row = out_orow_reg;
    assign out_ch.box_span_cols  = out_scol_reg;
    assign out_ch.box_span_rows  = out_srow_reg;

endmodule

[sim/hbef_tb_if.sv]
`timescale 1ns / 1ps

// The channel interfaces come from the RTL file list; this file only holds the
// per-side idle profile shared by the driver and the monitor.
package hbef_tb_pkg;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

endpackage

[sim/tb_homography_box_event_filter.sv]
`timescale 1ns / 1ps

module tb_homography_box_event_filter;
    import hbef_pkg::*;
    import hbef_tb_pkg::*;

    typedef struct {
        logic       req_type;
        logic [9:0] ecol, erow, bminr, bminc, bmaxr, bmaxc;
    } req_word_t;

    typedef struct {
        logic                        kind;
        logic [COORD_BITS-1:0]       pcol, prow;
        logic [OUT_BITS-1:0]         ocol, orow;
        logic signed [SPAN_BITS-1:0] scol, srow;
    } res_word_t;

    logic clk;
    logic rst_n;

    hbef_in_if  in_ch ();
    hbef_out_if out_ch ();
    hbef_cfg_if cfg_ch ();

    homography_box_event_filter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    req_word_t pending_reqs[$];
    res_word_t expected_results[$];

    logic [63:0]  h_pair[4];
    logic [31:0]  h22;
    logic [10:0]  sens_w, sens_h;
    logic [17:0]  box_min_c, box_max_c, box_min_r, box_max_r;

    int  mismatches;
    int  fail_count;
    int  idle_cycles;
    int  in_gap, out_gap;
    bit  drive_en;
    bit  cfg_busy;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic queue_req(input req_word_t w);
        pending_reqs = {pending_reqs, w};
    endtask

    function automatic longint coef(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic logic [10:0] dim_cap(logic [10:0] d);
        return (d > 11'd1024) ? 11'd1024 : d;
    endfunction

    function automatic logic [17:0] quotient_clamped(longint p, longint w, logic [10:0] dim);
        longint   hi;
        longint unsigned pm, wm, q;
        logic [10:0] d;
        d = dim_cap(dim);
        if (d == 0)
        begin
            return 18'd0;
        end
        hi = longint'(d - 1) << FRAC_BITS;
        if (w == 0)
        begin
            return (p >= 0) ? 18'(hi) : 18'd0;
        end
        pm = (p < 0) ? -p : p;
        wm = (w < 0) ? -w : w;
        q = (pm << FRAC_BITS) / wm;
        if (q == 0 || ((p < 0) != (w < 0)))
        begin
            return 18'd0;
        end
        if (q > longint'(hi))
        begin
            return 18'(hi);
        end
        return 18'(q);
    endfunction

    task automatic map_corner(input logic [9:0] c, input logic [9:0] r,
                              output logic [17:0] oc, output logic [17:0] orw);
        longint ci, ri, px, py, pw;
        ci = c;
        ri = r;
        px = ci * coef(h_pair[0][31:0]) + ri * coef(h_pair[1][63:32]) + coef(h_pair[3][31:0]);
        py = ci * coef(h_pair[0][63:32]) + ri * coef(h_pair[2][31:0]) + coef(h_pair[3][63:32]);
        pw = ci * coef(h_pair[1][31:0]) + ri * coef(h_pair[2][63:32]) + coef(h22);
        oc = quotient_clamped(px, pw, sens_w);
        orw = quotient_clamped(py, pw, sens_h);
    endtask

    task automatic predict_filter(input req_word_t w);
        res_word_t res;
        logic [17:0] cq, rq;
        res = '{default: 0};
        if (w.req_type == REQ_EVENT)
        begin
            cq = {w.ecol, 8'd0};
            rq = {w.erow, 8'd0};
            if (w.ecol >= dim_cap(sens_w) || w.erow >= dim_cap(sens_h))
            begin
                return;
            end
            if (cq < box_min_c || cq > box_max_c || rq < box_min_r || rq > box_max_r)
            begin
                return;
            end
            res.kind = KIND_EVENT;
            res.pcol = w.ecol;
            res.prow = w.erow;
        end
        else
        begin
            map_corner(w.bminc, w.bminr, box_min_c, box_min_r);
            map_corner(w.bmaxc, w.bmaxr, box_max_c, box_max_r);
            res.kind = KIND_BOX;
            res.ocol = box_min_c;
            res.orow = box_min_r;
            res.scol = SPAN_BITS'({1'b0, box_max_c} - {1'b0, box_min_c});
            res.srow = SPAN_BITS'({1'b0, box_max_r} - {1'b0, box_min_r});
        end
        expected_results = {expected_results, res};
    endtask

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_filter(pending_reqs.pop_front());
                in_gap = idle_gap();
            end
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (drive_en && pending_reqs.size() > 0)
                begin
                    in_ch.valid       <= 1'b1;
                    in_ch.req_type    <= pending_reqs[0].req_type;
                    in_ch.event_col   <= pending_reqs[0].ecol;
                    in_ch.event_row   <= pending_reqs[0].erow;
                    in_ch.box_min_row <= pending_reqs[0].bminr;
                    in_ch.box_min_col <= pending_reqs[0].bminc;
                    in_ch.box_max_row <= pending_reqs[0].bmaxr;
                    in_ch.box_max_col <= pending_reqs[0].bmaxc;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor.
    always @(posedge clk or negedge rst_n)
    begin
        res_word_t e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (mismatches < 10)
                    begin
                        $display("Unexpected word: kind %0d", out_ch.result_kind);
                    end
                    mismatches++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e.kind !== out_ch.result_kind || e.pcol !== out_ch.pass_col
                        || e.prow !== out_ch.pass_row || e.ocol !== out_ch.box_origin_col
                        || e.orow !== out_ch.box_origin_row || e.scol !== out_ch.box_span_cols
                        || e.srow !== out_ch.box_span_rows)
                    begin
                        fail_count++;
                        if (mismatches < 10)
                        begin
                            $display("Mismatch exp k%0d c%0d r%0d o%0d,%0d s%0d,%0d",
                                     e.kind, e.pcol, e.prow, e.ocol, e.orow, e.scol, e.srow);
                            $display("         got k%0d c%0d r%0d o%0d,%0d s%0d,%0d",
                                     out_ch.result_kind, out_ch.pass_col, out_ch.pass_row,
                                     out_ch.box_origin_col, out_ch.box_origin_row,
                                     out_ch.box_span_cols, out_ch.box_span_rows);
                        end
                        mismatches++;
                    end
                end
                out_gap = idle_gap();
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || (pending_reqs.size() == 0
            && expected_results.size() == 0 && !cfg_busy))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_busy = 1'b1;
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_H_PAIR_0:      h_pair[0] = val;
            CFG_H_PAIR_1:      h_pair[1] = val;
            CFG_H_PAIR_2:      h_pair[2] = val;
            CFG_H_PAIR_3:      h_pair[3] = val;
            CFG_H_LAST:        h22 = val[31:0];
            CFG_SENSOR_WIDTH:  sens_w = val[10:0];
            CFG_SENSOR_HEIGHT: sens_h = val[10:0];
            default: ;
        endcase
        cfg_busy = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_ch.valid)
        begin
            @(posedge clk);
        end
        repeat (150) @(posedge clk);
    endtask

    function automatic logic [63:0] q20_pair(int lo, int hi);
        return {32'(hi), 32'(lo)};
    endfunction

    function automatic req_word_t rand_event();
        req_word_t w;
        w = '{default: 0};
        w.req_type = REQ_EVENT;
        w.ecol = (($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 320)));
        w.erow = (($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 260)));
        w.bminr = 10'($urandom);
        w.bmaxc = 10'($urandom);
        return w;
    endfunction

    function automatic req_word_t rand_box();
        req_word_t w;
        w.req_type = REQ_BOX;
        w.ecol = 10'($urandom);
        w.erow = 10'($urandom);
        if ($urandom_range(0, 4) == 0)
        begin
            w.bminr = 10'($urandom);
            w.bminc = 10'($urandom);
            w.bmaxr = 10'($urandom);
            w.bmaxc = 10'($urandom);
        end
        else
        begin
            w.bminr = 10'($urandom_range(0, 200));
            w.bminc = 10'($urandom_range(0, 250));
            w.bmaxr = w.bminr + 10'($urandom_range(0, 60));
            w.bmaxc = w.bminc + 10'($urandom_range(0, 60));
        end
        return w;
    endfunction

    function automatic req_word_t box_of(int c0, int r0, int c1, int r1);
        req_word_t w;
        w = '{default: 0};
        w.req_type = REQ_BOX;
        w.bminc = 10'(c0);
        w.bminr = 10'(r0);
        w.bmaxc = 10'(c1);
        w.bmaxr = 10'(r1);
        return w;
    endfunction

    function automatic req_word_t event_at(int c, int r);
        req_word_t w;
        w = '{default: 0};
        w.req_type = REQ_EVENT;
        w.ecol = 10'(c);
        w.erow = 10'(r);
        return w;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            queue_req(($urandom_range(0, 9) == 0) ? rand_box() : rand_event());
        end
        wait_drained();
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.req_type = 1'b0;
        in_ch.event_col = '0;
        in_ch.event_row = '0;
        in_ch.box_min_row = '0;
        in_ch.box_min_col = '0;
        in_ch.box_max_row = '0;
        in_ch.box_max_col = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        h_pair[0] = RST_H_PAIR_0;
        h_pair[1] = RST_H_PAIR_1;
        h_pair[2] = RST_H_PAIR_2;
        h_pair[3] = RST_H_PAIR_3;
        h22 = RST_H_LAST;
        sens_w = RST_SENSOR_WIDTH;
        sens_h = RST_SENSOR_HEIGHT;
        {box_min_c, box_max_c, box_min_r, box_max_r} = '0;
        mismatches = 0;
        fail_count = 0;
        idle_cycles = 0;
        drive_en = 1'b0;
        cfg_busy = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drive_en = 1'b1;

        // Reset box is the single pixel at the origin.
        queue_req(event_at(0, 0));
        queue_req(event_at(1, 0));
        queue_req(box_of(0, 0, 1023, 1023));
        queue_req(event_at(303, 239));
        queue_req(event_at(304, 10));
        queue_req(event_at(1023, 1023));
        queue_req(box_of(50, 40, 10, 5));
        queue_req(event_at(20, 20));
        queue_req(box_of(10, 10, 100, 80));
        queue_req(event_at(10, 10));
        queue_req(event_at(100, 80));
        queue_req(event_at(101, 80));
        wait_drained();

        // Zero divisor, negative coordinates and an oversized then empty sensor.
        write_reg(CFG_H_LAST, 64'd0);
        write_reg(CFG_H_PAIR_3, q20_pair(-5 <<< 20, 3 <<< 20));
        write_reg(CFG_SENSOR_WIDTH, 64'h7FF);
        write_reg(CFG_SENSOR_HEIGHT, 64'd1024);
        queue_req(box_of(0, 0, 1023, 1023));
        queue_req(event_at(1023, 1023));
        wait_drained();
        write_reg(CFG_SENSOR_WIDTH, 64'd0);
        write_reg(CFG_SENSOR_HEIGHT, 64'd1);
        write_reg(CFG_H_LAST, 64'hFFFF_FFFF_8000_0000);
        write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(box_of(3, 3, 7, 7));
        queue_req(event_at(0, 0));
        wait_drained();

        // Extreme coefficients.
        write_reg(CFG_H_PAIR_0, 64'h8000_0000_7FFF_FFFF);
        write_reg(CFG_H_PAIR_1, 64'h7FFF_FFFF_8000_0000);
        write_reg(CFG_H_PAIR_2, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_H_PAIR_3, 64'h0000_0000_FFFF_FFFF);
        write_reg(CFG_H_LAST, 64'h7FFF_FFFF);
        write_reg(CFG_SENSOR_WIDTH, 64'd1025);
        write_reg(CFG_SENSOR_HEIGHT, 64'd1);
        queue_req(box_of(1023, 0, 0, 1023));
        queue_req(box_of(1023, 1023, 1023, 1023));
        wait_drained();

        // Back to identity with a default-sized sensor, then random traffic.
        write_reg(CFG_H_PAIR_0, RST_H_PAIR_0);
        write_reg(CFG_H_PAIR_1, RST_H_PAIR_1);
        write_reg(CFG_H_PAIR_2, RST_H_PAIR_2);
        write_reg(CFG_H_PAIR_3, RST_H_PAIR_3);
        write_reg(CFG_H_LAST, RST_H_LAST);
        write_reg(CFG_SENSOR_WIDTH, RST_SENSOR_WIDTH);
        write_reg(CFG_SENSOR_HEIGHT, RST_SENSOR_HEIGHT);
        run_random(300);

        // Mild scale, shift and perspective.
        write_reg(CFG_H_PAIR_0, q20_pair(32'h0010_8000, 32'h0000_4000));
        write_reg(CFG_H_PAIR_1, q20_pair(32'h0000_0100, -32'sh0000_3000));
        write_reg(CFG_H_PAIR_2, q20_pair(32'h000F_0000, 32'h0000_0080));
        write_reg(CFG_H_PAIR_3, q20_pair(32'h00A0_0000, -32'sh0050_0000));
        write_reg(CFG_H_LAST, 64'(32'h0011_0000));
        write_reg(CFG_SENSOR_WIDTH, 64'd1024);
        write_reg(CFG_SENSOR_HEIGHT, 64'd512);
        run_random(250);

        // Fully random matrix.
        write_reg(CFG_H_PAIR_0, {$urandom, $urandom});
        write_reg(CFG_H_PAIR_1, {$urandom, $urandom});
        write_reg(CFG_H_PAIR_2, {$urandom, $urandom});
        write_reg(CFG_H_PAIR_3, {$urandom, $urandom});
        write_reg(CFG_H_LAST, 64'($urandom));
        write_reg(CFG_SENSOR_WIDTH, 64'($urandom_range(1, 1024)));
        write_reg(CFG_SENSOR_HEIGHT, 64'($urandom_range(1, 1024)));
        run_random(250);

        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
